// ===== rtl/pat_pkg.sv =====
// Shared types and constants for the pending acknowledgement table.
package pat_pkg;

    // Field widths
    localparam int OPCODE_W = 2;
    localparam int OID_W    = 32;
    localparam int GEN_W    = 64;
    localparam int TIME_W   = 64;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // Default table depth
    localparam int DEFAULT_ENTRIES = 16;

    // Opcodes (code three behaves as a lookup)
    localparam logic [OPCODE_W-1:0] OP_REGISTER = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LOOKUP   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REFRESHED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

    // Write request into the entry store
    typedef struct packed {
        logic key_we;   // write output id and generation
        logic time_we;  // write creation time
    } wr_req_t;

endpackage

// ===== rtl/pending_ack_table.sv =====
// Top level of the pending acknowledgement table: sequencer, valid bits and result register.
// Each transaction (start high while busy is low) scans all ENTRIES slots through one
// registered read port and one shared 96-bit key comparator, one slot per cycle, then
// applies the update in a final apply state. The result appears on status, age_time and
// entry_count with done high for exactly one cycle; busy drops in that same cycle. A new
// transaction is taken only once the last one has been answered. The receiver cannot stall:
// the result is shown once and must be captured while done is high. A register of a new
// key on a full table changes nothing and reports full. Reset empties the table at once.
module pending_ack_table #(
    parameter int ENTRIES = pat_pkg::DEFAULT_ENTRIES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pat_pkg::OPCODE_W-1:0]      opcode,
    input  logic [pat_pkg::OID_W-1:0]         dest_id,
    input  logic [pat_pkg::GEN_W-1:0]         generation,
    input  logic signed [pat_pkg::TIME_W-1:0] now_time,
    output logic                              done,
    output logic [pat_pkg::STATUS_W-1:0]      status,
    output logic signed [pat_pkg::TIME_W-1:0] age_time,
    output logic [pat_pkg::COUNT_W-1:0]       entry_count
);
    import pat_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int VC_W  = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    // Control state
    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               pend_reg, pend_next;
    logic               hit_reg, hit_next;
    logic               free_reg, free_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [VC_W-1:0]    count_reg, count_next;
    logic               done_reg, done_next;

    // Payload
    logic [IDX_W-1:0]         cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]         hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]         free_idx_reg, free_idx_next;
    logic [TIME_W-1:0]        created_reg, created_next;
    logic [OPCODE_W-1:0]      op_reg;
    logic [OID_W-1:0]         oid_reg;
    logic [GEN_W-1:0]         gen_reg;
    logic signed [TIME_W-1:0] now_reg;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic signed [TIME_W-1:0] age_reg, age_next;

    // Store interface
    wr_req_t           wr;
    logic [IDX_W-1:0]  waddr;
    logic              rd_en;
    logic [IDX_W-1:0]  raddr;
    logic [OID_W-1:0]  rd_output;
    logic [GEN_W-1:0]  rd_generation;
    logic [TIME_W-1:0] rd_created;

    logic accept;
    logic key_eq;
    logic slot_valid;
    logic positive;

    assign accept = start && (state_reg == S_IDLE);

    pat_store #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_store (
        .clk           (clk),
        .wr            (wr),
        .waddr         (waddr),
        .wr_output     (oid_reg),
        .wr_generation (gen_reg),
        .wr_created    (now_reg),
        .rd_en         (rd_en),
        .raddr         (raddr),
        .rd_output     (rd_output),
        .rd_generation (rd_generation),
        .rd_created    (rd_created)
    );

    // Shared key comparator on the slot read last cycle
    assign key_eq     = (rd_output == oid_reg) && (rd_generation == gen_reg);
    assign slot_valid = valid_reg[cmp_idx_reg];
    assign positive   = (created_reg != '0) && !created_reg[TIME_W-1];

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pend_next     = 1'b0;
        hit_next      = hit_reg;
        free_next     = free_reg;
        valid_next    = valid_reg;
        count_next    = count_reg;
        done_next     = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        hit_idx_next  = hit_idx_reg;
        free_idx_next = free_idx_reg;
        created_next  = created_reg;
        status_next   = status_reg;
        age_next      = age_reg;
        wr            = '0;
        waddr         = hit_idx_reg;
        rd_en         = 1'b0;
        raddr         = cnt_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                end
            end

            S_SCAN:
            begin
                // issue one slot read per cycle
                if (cnt_reg < CNT_W'(ENTRIES))
                begin
                    rd_en        = 1'b1;
                    pend_next    = 1'b1;
                    cmp_idx_next = cnt_reg[IDX_W-1:0];
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
                // compare the slot read last cycle; first match and first free slot win
                if (pend_reg)
                begin
                    if (!hit_reg && slot_valid && key_eq)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = cmp_idx_reg;
                        created_next = rd_created;
                    end
                    if (!free_reg && !slot_valid)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = cmp_idx_reg;
                    end
                    if (cmp_idx_reg == LAST_IDX)
                    begin
                        state_next = S_APPLY;
                    end
                end
            end

            S_APPLY:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                age_next   = '0;
                unique case (op_reg)
                    OP_REGISTER:
                    begin
                        if (hit_reg)
                        begin
                            wr.time_we  = 1'b1;
                            status_next = ST_REFRESHED;
                        end
                        else if (free_reg)
                        begin
                            wr.key_we                = 1'b1;
                            wr.time_we               = 1'b1;
                            waddr                    = free_idx_reg;
                            valid_next[free_idx_reg] = 1'b1;
                            count_next               = count_reg + VC_W'(1);
                            status_next              = ST_ADDED;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            valid_next[hit_idx_reg] = 1'b0;
                            count_next              = count_reg - VC_W'(1);
                            status_next             = ST_REMOVED;
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        // lookup, also for the unused opcode
                        if (hit_reg)
                        begin
                            status_next = ST_FOUND;
                            age_next    = positive ? (now_reg - $signed(created_reg))
                                                   : -64'sd1;
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                            age_next    = -64'sd1;
                        end
                    end
                endcase
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            valid_reg <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            hit_reg   <= hit_next;
            free_reg  <= free_next;
            valid_reg <= valid_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        created_reg  <= created_next;
        status_reg   <= status_next;
        age_reg      <= age_next;
        if (accept)
        begin
            op_reg  <= opcode;
            oid_reg <= dest_id;
            gen_reg <= generation;
            now_reg <= now_time;
        end
    end

    // Outputs
    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign age_time    = age_reg;
    assign entry_count = COUNT_W'(count_reg);

`ifndef SYNTHESIS
    // The count always matches the number of valid slots
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(count_reg))
        else $error("entry count does not match valid slots");

    // A result is only strobed once the sequencer has gone idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result strobed while busy");

    // Full is reported only with every slot valid
    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == ST_FULL)) |-> (valid_reg == '1))
        else $error("full reported with a free slot");

    // An accepted transaction makes the block busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not start the scan");
`endif

endmodule

// ===== rtl/pat_store.sv =====
// Entry store: key and creation time per slot, one write and one registered read port.
module pat_store #(
    parameter int ENTRIES = pat_pkg::DEFAULT_ENTRIES,
    parameter int IDX_W   = 4
) (
    input  logic                      clk,
    input  pat_pkg::wr_req_t          wr,
    input  logic [IDX_W-1:0]          waddr,
    input  logic [pat_pkg::OID_W-1:0] wr_output,
    input  logic [pat_pkg::GEN_W-1:0] wr_generation,
    input  logic [pat_pkg::TIME_W-1:0] wr_created,
    input  logic                      rd_en,
    input  logic [IDX_W-1:0]          raddr,
    output logic [pat_pkg::OID_W-1:0] rd_output,
    output logic [pat_pkg::GEN_W-1:0] rd_generation,
    output logic [pat_pkg::TIME_W-1:0] rd_created
);
    import pat_pkg::*;

    logic [OID_W-1:0]  mem_output     [ENTRIES];
    logic [GEN_W-1:0]  mem_generation [ENTRIES];
    logic [TIME_W-1:0] mem_created    [ENTRIES];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.key_we)
        begin
            mem_output[waddr]     <= wr_output;
            mem_generation[waddr] <= wr_generation;
        end
        if (wr.time_we)
        begin
            mem_created[waddr] <= wr_created;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_output     <= mem_output[raddr];
            rd_generation <= mem_generation[raddr];
            rd_created    <= mem_created[raddr];
        end
    end

endmodule

// ===== test/pending_ack_table_tb.sv =====
// Self-checking testbench for the pending acknowledgement table: directed and random transactions.
`timescale 1ns / 100ps

module pending_ack_table_tb;

    import pat_pkg::*;

    localparam int TBL_DEPTH    = DEFAULT_ENTRIES;
    localparam int STALL_LIMIT  = 1000;
    localparam int PHASE_LEN    = 120;
    localparam int POOL_MAX     = 32;
    localparam logic [OPCODE_W-1:0] OP_LOOKUP_ALT = 2'd3;  // spare code, acts as a lookup

    localparam logic [OID_W-1:0]         OID_MAX  = '1;
    localparam logic [GEN_W-1:0]         GEN_MAX  = '1;
    localparam logic signed [TIME_W-1:0] TIME_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [TIME_W-1:0] TIME_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [TIME_W-1:0] AGE_NONE = -64'sd1;

    typedef struct {
        logic [OPCODE_W-1:0]      op;
        logic [OID_W-1:0]         oid;
        logic [GEN_W-1:0]         gen;
        logic signed [TIME_W-1:0] now;
        bit                       drain;  // hold off until the table has answered everything
    } ack_req_t;

    typedef struct {
        logic [STATUS_W-1:0]      status;
        logic signed [TIME_W-1:0] age;
        logic [COUNT_W-1:0]       count;
    } ack_resp_t;

    // DUT ports
    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [OPCODE_W-1:0]        opcode = '0;
    logic [OID_W-1:0]           dest_id = '0;
    logic [GEN_W-1:0]           generation = '0;
    logic signed [TIME_W-1:0]   now_time = '0;
    logic                       done;
    logic [STATUS_W-1:0]        status;
    logic signed [TIME_W-1:0]   age_time;
    logic [COUNT_W-1:0]         entry_count;

    // Stimulus and expected responses
    ack_req_t  req_q[$];
    ack_resp_t resp_q[$];
    int        n_issued = 0;
    int        n_checked = 0;
    int        n_errors = 0;
    int        status_seen[6];
    int        stall_cycles = 0;

    // Shadow of the table
    bit                       tbl_valid[TBL_DEPTH];
    logic [OID_W-1:0]         tbl_oid[TBL_DEPTH];
    logic [GEN_W-1:0]         tbl_gen[TBL_DEPTH];
    logic signed [TIME_W-1:0] tbl_created[TBL_DEPTH];
    int                       tbl_count = 0;

    // Key pool for the random part
    logic [OID_W-1:0]         pool_oid[POOL_MAX];
    logic [GEN_W-1:0]         pool_gen[POOL_MAX];
    logic signed [TIME_W-1:0] clock_us;

    pending_ack_table #(
        .ENTRIES    (TBL_DEPTH)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .dest_id    (dest_id),
        .generation (generation),
        .now_time   (now_time),
        .done       (done),
        .status     (status),
        .age_time   (age_time),
        .entry_count(entry_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Apply one operation to the shadow table and return the response it should give
    function automatic ack_resp_t apply_ack_op(input ack_req_t rq);
        ack_resp_t rs;
        int        hit;
        int        vacant;
        hit    = -1;
        vacant = -1;
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            if (hit < 0 && tbl_valid[i] && tbl_oid[i] == rq.oid && tbl_gen[i] == rq.gen)
                hit = i;
            if (vacant < 0 && !tbl_valid[i])
                vacant = i;
        end
        rs.age = '0;
        case (rq.op)
            OP_REGISTER:
            begin
                if (hit >= 0)
                begin
                    tbl_created[hit] = rq.now;
                    rs.status = ST_REFRESHED;
                end
                else if (vacant < 0)
                begin
                    rs.status = ST_FULL;
                end
                else
                begin
                    tbl_valid[vacant]   = 1'b1;
                    tbl_oid[vacant]     = rq.oid;
                    tbl_gen[vacant]     = rq.gen;
                    tbl_created[vacant] = rq.now;
                    tbl_count++;
                    rs.status = ST_ADDED;
                end
            end
            OP_REMOVE:
            begin
                if (hit >= 0)
                begin
                    tbl_valid[hit] = 1'b0;
                    tbl_count--;
                    rs.status = ST_REMOVED;
                end
                else
                begin
                    rs.status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                // lookup; age wraps at 64 bits, none for a non-positive creation time
                if (hit >= 0)
                begin
                    rs.status = ST_FOUND;
                    rs.age    = (tbl_created[hit] > 0) ? rq.now - tbl_created[hit] : AGE_NONE;
                end
                else
                begin
                    rs.status = ST_NOT_FOUND;
                    rs.age    = AGE_NONE;
                end
            end
        endcase
        rs.count = tbl_count[COUNT_W-1:0];
        return rs;
    endfunction

    task automatic queue_req(input logic [OPCODE_W-1:0] op, input logic [OID_W-1:0] oid,
                             input logic [GEN_W-1:0] gen, input logic signed [TIME_W-1:0] now,
                             input bit drain);
        ack_req_t rq;
        rq.op    = op;
        rq.oid   = oid;
        rq.gen   = gen;
        rq.now   = now;
        rq.drain = drain;
        req_q.push_back(rq);
    endtask

    // Fresh pool; some neighbors share the output id or the generation to exercise partial matches
    task automatic refill_pool();
        for (int k = 0; k < POOL_MAX; k++)
        begin
            pool_oid[k] = $urandom;
            pool_gen[k] = {$urandom, $urandom};
            if (k % 4 == 1)
                pool_oid[k] = pool_oid[k-1];
            if (k % 4 == 2)
                pool_gen[k] = pool_gen[k-1];
        end
    endtask

    // Mostly a rising clock, now and then an edge value or noise
    function automatic logic signed [TIME_W-1:0] pick_now();
        clock_us = clock_us + $urandom_range(5000);
        case ($urandom_range(15))
            0:       return '0;
            1:       return AGE_NONE;
            2:       return TIME_MAX;
            3:       return TIME_MIN;
            4:       return {$urandom, $urandom};
            5:       return 64'sd1;
            default: return clock_us;
        endcase
    endfunction

    // Driver: offers the head of req_q, predicts the response on acceptance
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        bit offer;
        int outstanding;
        int idle_pct;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            offer = start;
            if (start && !busy)
            begin
                resp_q.push_back(apply_ack_op(req_q[0]));
                void'(req_q.pop_front());
                n_issued++;
                offer = 1'b0;
            end
            if (!offer && req_q.size() != 0)
            begin
                case ((n_issued / PHASE_LEN) % 3)
                    0:       idle_pct = 0;
                    1:       idle_pct = 55;
                    default: idle_pct = 10;
                endcase
                outstanding = n_issued - n_checked - (done ? 1 : 0);
                offer = !(req_q[0].drain && outstanding != 0) &&
                        ($urandom_range(99) >= idle_pct);
                if (offer)
                begin
                    opcode     <= req_q[0].op;
                    dest_id    <= req_q[0].oid;
                    generation <= req_q[0].gen;
                    now_time   <= req_q[0].now;
                end
            end
            start <= offer;
        end
    end

    // Monitor: every done pulse is one result, checked against the oldest expectation
    always @(posedge clk)
    begin : check_proc
        ack_resp_t want;
        if (rst_n && done)
        begin
            if (resp_q.size() == 0)
            begin
                $display("%0t: unexpected result status %0d age %0d count %0d",
                         $time, status, age_time, entry_count);
                n_errors++;
            end
            else
            begin
                want = resp_q.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                    n_errors++;
                end
                if (age_time !== want.age)
                begin
                    $display("%0t: age_time expected %0d actual %0d", $time, want.age, age_time);
                    n_errors++;
                end
                if (entry_count !== want.count)
                begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.count, entry_count);
                    n_errors++;
                end
                if (status < 6)
                    status_seen[status]++;
                n_checked <= n_checked + 1;
            end
        end
    end

    // Watchdog: too long without an accepted transaction or a result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin : stim_proc
        int                  reg_pct;
        int                  pool_n;
        int                  k;
        int                  r;
        logic [OPCODE_W-1:0] op;
        logic [OID_W-1:0]    oid;
        logic [GEN_W-1:0]    gen;

        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            tbl_valid[i]   = 1'b0;
            tbl_oid[i]     = '0;
            tbl_gen[i]     = '0;
            tbl_created[i] = '0;
        end
        for (int i = 0; i < 6; i++)
            status_seen[i] = 0;

        // Directed: empty table, extreme keys and times, wrap, non-positive creation times
        queue_req(OP_LOOKUP, '0, '0, 64'sd5, 1'b0);
        queue_req(OP_REMOVE, OID_MAX, GEN_MAX, 64'sd5, 1'b0);
        queue_req(OP_REGISTER, OID_MAX, GEN_MAX, TIME_MAX, 1'b0);
        queue_req(OP_LOOKUP, OID_MAX, GEN_MAX, TIME_MIN, 1'b0);
        queue_req(OP_REGISTER, OID_MAX, GEN_MAX, '0, 1'b0);
        queue_req(OP_LOOKUP_ALT, OID_MAX, GEN_MAX, 64'sd100, 1'b0);
        queue_req(OP_REGISTER, '0, '0, 64'sd1, 1'b0);
        queue_req(OP_LOOKUP, '0, '0, 64'sd1, 1'b0);
        queue_req(OP_LOOKUP, OID_MAX, '0, 64'sd1, 1'b0);
        queue_req(OP_REGISTER, OID_MAX, GEN_MAX, AGE_NONE, 1'b0);
        queue_req(OP_LOOKUP, OID_MAX, GEN_MAX, 64'sd7, 1'b0);
        queue_req(OP_REMOVE, OID_MAX, GEN_MAX, '0, 1'b0);
        // fill to the brim, overflow, then free one slot and reuse it
        for (int i = 0; i < TBL_DEPTH - 1; i++)
            queue_req(OP_REGISTER, 32'h1000_0000 + i, 64'(i), 64'sd1000 + i, 1'b0);
        queue_req(OP_REGISTER, 32'h2000_0000, GEN_MAX, 64'sd2000, 1'b0);
        queue_req(OP_REMOVE, '0, '0, 64'sd2001, 1'b0);
        queue_req(OP_REGISTER, 32'h2000_0000, GEN_MAX, 64'sd2002, 1'b0);

        // Random: blocks that lean toward filling, draining or churning the table
        clock_us = 64'(1 + $urandom_range(1000));
        for (int blk = 0; blk < 11; blk++)
        begin
            if (blk % 3 == 0)
                refill_pool();
            pool_n = 4 + $urandom_range(POOL_MAX - 4);
            case (blk % 4)
                0:       reg_pct = 70;
                1:       reg_pct = 40;
                2:       reg_pct = 20;
                default: reg_pct = 55;
            endcase
            for (int j = 0; j < 100; j++)
            begin
                r = $urandom_range(99);
                if (r < reg_pct)
                    op = OP_REGISTER;
                else if (r < reg_pct + (100 - reg_pct) / 2)
                    op = OP_REMOVE;
                else
                    op = ($urandom_range(9) == 0) ? OP_LOOKUP_ALT : OP_LOOKUP;
                if ($urandom_range(99) < 88)
                begin
                    k   = $urandom_range(pool_n - 1);
                    oid = pool_oid[k];
                    gen = pool_gen[k];
                end
                else
                begin
                    oid = $urandom;
                    gen = {$urandom, $urandom};
                end
                queue_req(op, oid, gen, pick_now(), (j == 0) && (blk % 2 == 0));
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (req_q.size() != 0 || n_checked != n_issued)
            @(posedge clk);
        repeat (TBL_DEPTH + 5) @(posedge clk);

        $display("Ran %0d transactions through no-idle, heavy-idle and light-idle stretches",
                 n_checked);
        $display("added %0d, refreshed %0d, removed %0d, missing %0d, found %0d, full %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
